FILE: rtl/esp_pkg.sv
// Shared types, register indexes and constants for the spindle speed controller.
package esp_pkg;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_RPM_SCALE     = 3'd0;
  localparam cfg_idx_t REG_TICK_RATE     = 3'd1;
  localparam cfg_idx_t REG_BASE_DUTY     = 3'd2;
  localparam cfg_idx_t REG_KP            = 3'd3;
  localparam cfg_idx_t REG_KI_PER_TICK   = 3'd4;
  localparam cfg_idx_t REG_KD_TIMES_RATE = 3'd5;
  localparam cfg_idx_t REG_ERROR_LIMIT   = 3'd6;
  localparam cfg_idx_t REG_MAX_DUTY      = 3'd7;

  localparam logic [31:0] RST_RPM_SCALE     = 32'd218453;
  localparam logic [9:0]  RST_TICK_RATE     = 10'd20;
  localparam logic [16:0] RST_BASE_DUTY     = 17'd6554;
  localparam logic [31:0] RST_KP            = 32'd1678;
  localparam logic [31:0] RST_KI_PER_TICK   = 32'd84;
  localparam logic [31:0] RST_KD_TIMES_RATE = 32'd33554;
  localparam logic [23:0] RST_ERROR_LIMIT   = 24'd64000;
  localparam logic [16:0] RST_MAX_DUTY      = 17'd65536;

  // x/10 for x < 2^24: (x * ceil(2^27/10)) >> 27 is exact
  localparam logic [23:0] DIV10_RECIP = 24'd13421773;

  // 30 rpm in Q16.8
  localparam logic [23:0] HOLD_RPM    = 24'd7680;
  localparam logic [16:0] DUTY_FULL   = 17'd65536;
  localparam logic [23:0] RPM_SAT     = 24'hFFFFFF;
  localparam logic [15:0] TICKS_SAT   = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MRPM,
    ST_SAT,
    ST_MDIV,
    ST_ERR,
    ST_MI,
    ST_MP,
    ST_MD,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MRPM,
    OP_SAT,
    OP_MDIV,
    OP_ERR,
    OP_MI,
    OP_MP,
    OP_MD,
    OP_SUM,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

endpackage

FILE: rtl/esp_in_if.sv
// Tick input channel: encoder count, target speed and on/off commands.
interface esp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] encoder_count;
  logic        [15:0] setpoint_rpm;
  logic               start_cmd;
  logic               stop_cmd;

  modport source (output valid, encoder_count, setpoint_rpm, start_cmd, stop_cmd,
                  input ready);
  modport sink   (input valid, encoder_count, setpoint_rpm, start_cmd, stop_cmd,
                  output ready);
endinterface

FILE: rtl/esp_out_if.sv
// Result channel: duty, measured speed and run status.
interface esp_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] pwm_duty;
  logic [23:0] measured_rpm;
  logic        running;

  modport source (output valid, pwm_duty, measured_rpm, running, input ready);
  modport sink   (input valid, pwm_duty, measured_rpm, running, output ready);
endinterface

FILE: rtl/esp_ctrl.sv
// Sequencer: steps the datapath through one tick and owns the handshakes.
module esp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output esp_pkg::cmd_t cmd
);

  esp_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = esp_pkg::OP_NONE;
    case (state_r)
      esp_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = esp_pkg::OP_LOAD;
          state_nxt = esp_pkg::ST_MRPM;
        end
      end
      esp_pkg::ST_MRPM: begin
        cmd.op    = esp_pkg::OP_MRPM;
        state_nxt = esp_pkg::ST_SAT;
      end
      esp_pkg::ST_SAT: begin
        cmd.op    = esp_pkg::OP_SAT;
        state_nxt = esp_pkg::ST_MDIV;
      end
      esp_pkg::ST_MDIV: begin
        cmd.op    = esp_pkg::OP_MDIV;
        state_nxt = esp_pkg::ST_ERR;
      end
      esp_pkg::ST_ERR: begin
        cmd.op    = esp_pkg::OP_ERR;
        state_nxt = esp_pkg::ST_MI;
      end
      esp_pkg::ST_MI: begin
        cmd.op    = esp_pkg::OP_MI;
        state_nxt = esp_pkg::ST_MP;
      end
      esp_pkg::ST_MP: begin
        cmd.op    = esp_pkg::OP_MP;
        state_nxt = esp_pkg::ST_MD;
      end
      esp_pkg::ST_MD: begin
        cmd.op    = esp_pkg::OP_MD;
        state_nxt = esp_pkg::ST_SUM;
      end
      esp_pkg::ST_SUM: begin
        cmd.op    = esp_pkg::OP_SUM;
        state_nxt = esp_pkg::ST_DONE;
      end
      esp_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.op    = esp_pkg::OP_COMMIT;
          state_nxt = esp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = esp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == esp_pkg::OP_COMMIT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == esp_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == esp_pkg::OP_COMMIT |=> out_valid_r)
    else $error("result not presented after commit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == esp_pkg::ST_MRPM)
    else $error("sequence did not start after input transfer");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == esp_pkg::ST_DONE && out_valid_r && !out_ready
      |=> state_r == esp_pkg::ST_DONE)
    else $error("commit overran a pending result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != esp_pkg::ST_IDLE |-> cmd.op != esp_pkg::OP_LOAD)
    else $error("load issued mid-sequence");

endmodule

FILE: rtl/esp_dp.sv
// Datapath: config registers, loop state, shared multiplier and result register.
module esp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  esp_pkg::cmd_t      cmd,
  input  logic               cfg_we,
  input  esp_pkg::cfg_idx_t  cfg_idx,
  input  logic        [31:0] cfg_data,
  input  logic signed [31:0] in_count,
  input  logic        [15:0] in_target,
  input  logic               in_start,
  input  logic               in_stop,
  output logic        [16:0] duty_o,
  output logic        [23:0] rpm_o,
  output logic               running_o
);

  localparam logic signed [50:0] INT_LO = -51'sd65536;
  localparam logic signed [50:0] INT_HI = 51'sd65536;

  // configuration
  logic [31:0] rpm_scale_r, kp_r, ki_r, kd_r;
  logic [9:0]  tick_rate_r;
  logic [16:0] base_duty_r, max_duty_r;
  logic [23:0] error_limit_r;

  // state carried between ticks
  logic [31:0]        last_count_r;
  logic signed [17:0] integral_r;
  logic signed [24:0] prev_err_r;
  logic [15:0]        stall_r, dead_r;
  logic               spindle_on_r;

  // per-tick work registers
  logic [31:0]        mag_r, change_r;
  logic [15:0]        target_r;
  logic               on_r, neg_r;
  logic [23:0]        rpm_r;
  logic signed [24:0] err_r;
  logic signed [25:0] derr_r;
  logic signed [17:0] integ_r;
  logic signed [51:0] acc_r;
  logic signed [65:0] prod_r;

  // result register
  logic [16:0] duty_out_r;
  logic [23:0] rpm_out_r;
  logic        running_out_r;

  logic [31:0]        raw_w, mag_w, change_w;
  logic signed [24:0] diff_w, absdiff_full_w, err_raw_w, err_clamp_w, lim_w;
  logic [23:0]        absdiff_w;
  logic [20:0]        quot_w;
  logic signed [49:0] term_w;
  logic signed [50:0] isum_w;
  logic signed [17:0] iclamp_w;
  logic [16:0]        base_w, duty_clamp_w, duty_lim_w;
  logic [17:0]        stall4_w, tick3_w;
  logic               hold_w, stop_dead_w, run_after_w;
  logic [15:0]        dead_inc_w, dead_nxt_w, stall_inc_w;
  logic signed [32:0] mul_a, mul_b;

  assign raw_w    = in_count;
  assign mag_w    = raw_w[31] ? (~raw_w + 32'd1) : raw_w;
  assign change_w = (mag_w >= last_count_r) ? (mag_w - last_count_r) : (last_count_r - mag_w);

  assign diff_w         = $signed({1'b0, target_r, 8'd0}) - $signed({1'b0, rpm_r});
  assign absdiff_full_w = diff_w[24] ? -diff_w : diff_w;
  assign absdiff_w      = absdiff_full_w[23:0];

  assign quot_w      = prod_r[47:27];
  assign err_raw_w   = neg_r ? -$signed({4'b0, quot_w}) : $signed({4'b0, quot_w});
  assign lim_w       = $signed({1'b0, error_limit_r});
  assign err_clamp_w = (err_raw_w > lim_w) ? lim_w : err_raw_w;

  // arithmetic shift: floor of product / 2^16
  assign term_w = prod_r[65:16];
  assign isum_w = 51'(integral_r) + 51'(term_w);
  always_comb begin
    if (isum_w < INT_LO) begin
      iclamp_w = 18'(INT_LO);
    end else if (isum_w > INT_HI) begin
      iclamp_w = 18'(INT_HI);
    end else begin
      iclamp_w = isum_w[17:0];
    end
  end

  assign base_w = (base_duty_r > esp_pkg::DUTY_FULL) ? esp_pkg::DUTY_FULL : base_duty_r;

  always_comb begin
    if (acc_r < 52'sd0) begin
      duty_clamp_w = 17'd0;
    end else if (acc_r > 52'sd65536) begin
      duty_clamp_w = esp_pkg::DUTY_FULL;
    end else begin
      duty_clamp_w = acc_r[16:0];
    end
  end
  assign duty_lim_w = (duty_clamp_w > max_duty_r) ? max_duty_r : duty_clamp_w;

  assign stall4_w = {stall_r, 2'b00};
  assign tick3_w  = {8'd0, tick_rate_r} + {7'd0, tick_rate_r, 1'b0};
  assign hold_w   = (rpm_r < esp_pkg::HOLD_RPM) || (stall4_w < tick3_w);

  assign dead_inc_w  = (dead_r == esp_pkg::TICKS_SAT) ? dead_r : dead_r + 16'd1;
  assign stall_inc_w = (stall_r == esp_pkg::TICKS_SAT) ? stall_r : stall_r + 16'd1;
  assign dead_nxt_w  = (change_r == 32'd0) ? dead_inc_w : dead_r;
  assign stop_dead_w = (change_r == 32'd0) && (dead_nxt_w > {6'd0, tick_rate_r});
  assign run_after_w = on_r && !stop_dead_w;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      esp_pkg::OP_MRPM: begin
        mul_a = {1'b0, change_r};
        mul_b = {1'b0, rpm_scale_r};
      end
      esp_pkg::OP_MDIV: begin
        mul_a = {9'd0, absdiff_w};
        mul_b = {9'd0, esp_pkg::DIV10_RECIP};
      end
      esp_pkg::OP_MI: begin
        mul_a = {1'b0, ki_r};
        mul_b = {{8{err_r[24]}}, err_r};
      end
      esp_pkg::OP_MP: begin
        mul_a = {1'b0, kp_r};
        mul_b = {{8{err_r[24]}}, err_r};
      end
      esp_pkg::OP_MD: begin
        mul_a = {1'b0, kd_r};
        mul_b = {{7{derr_r[25]}}, derr_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_scale_r   <= esp_pkg::RST_RPM_SCALE;
      tick_rate_r   <= esp_pkg::RST_TICK_RATE;
      base_duty_r   <= esp_pkg::RST_BASE_DUTY;
      kp_r          <= esp_pkg::RST_KP;
      ki_r          <= esp_pkg::RST_KI_PER_TICK;
      kd_r          <= esp_pkg::RST_KD_TIMES_RATE;
      error_limit_r <= esp_pkg::RST_ERROR_LIMIT;
      max_duty_r    <= esp_pkg::RST_MAX_DUTY;
    end else if (cfg_we) begin
      case (cfg_idx)
        esp_pkg::REG_RPM_SCALE:     rpm_scale_r   <= cfg_data;
        esp_pkg::REG_TICK_RATE:     tick_rate_r   <= cfg_data[9:0];
        esp_pkg::REG_BASE_DUTY:     base_duty_r   <= cfg_data[16:0];
        esp_pkg::REG_KP:            kp_r          <= cfg_data;
        esp_pkg::REG_KI_PER_TICK:   ki_r          <= cfg_data;
        esp_pkg::REG_KD_TIMES_RATE: kd_r          <= cfg_data;
        esp_pkg::REG_ERROR_LIMIT:   error_limit_r <= cfg_data[23:0];
        esp_pkg::REG_MAX_DUTY:      max_duty_r    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      integral_r   <= '0;
      prev_err_r   <= '0;
      stall_r      <= '0;
      dead_r       <= '0;
      spindle_on_r <= 1'b0;
    end else if (cmd.op == esp_pkg::OP_COMMIT) begin
      last_count_r <= mag_r;
      spindle_on_r <= run_after_w;
      if (on_r) begin
        dead_r <= dead_nxt_w;
        if (hold_w) begin
          integral_r <= '0;
          prev_err_r <= '0;
          stall_r    <= stall_inc_w;
        end else begin
          integral_r <= integ_r;
          prev_err_r <= err_r;
        end
      end else begin
        integral_r <= '0;
        stall_r    <= '0;
        dead_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      esp_pkg::OP_LOAD: begin
        mag_r    <= mag_w;
        change_r <= change_w;
        target_r <= in_target;
        on_r     <= (spindle_on_r | in_start) & ~in_stop;
      end
      esp_pkg::OP_MRPM: prod_r <= mul_a * mul_b;
      esp_pkg::OP_SAT:  rpm_r  <= (|prod_r[63:32]) ? esp_pkg::RPM_SAT : prod_r[31:8];
      esp_pkg::OP_MDIV: begin
        prod_r <= mul_a * mul_b;
        neg_r  <= diff_w[24];
      end
      esp_pkg::OP_ERR: err_r <= err_clamp_w;
      esp_pkg::OP_MI: begin
        prod_r <= mul_a * mul_b;
        derr_r <= 26'(err_r) - 26'(prev_err_r);
      end
      esp_pkg::OP_MP: begin
        prod_r  <= mul_a * mul_b;
        integ_r <= iclamp_w;
      end
      esp_pkg::OP_MD: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= $signed({35'd0, base_w}) + 52'(integ_r) + 52'(term_w);
      end
      esp_pkg::OP_SUM: acc_r <= acc_r + 52'(term_w);
      esp_pkg::OP_COMMIT: begin
        rpm_out_r     <= rpm_r;
        running_out_r <= run_after_w;
        if (!on_r) begin
          duty_out_r <= 17'd0;
        end else if (hold_w) begin
          duty_out_r <= base_w;
        end else begin
          duty_out_r <= duty_lim_w;
        end
      end
      default: ;
    endcase
  end

  assign duty_o    = duty_out_r;
  assign rpm_o     = rpm_out_r;
  assign running_o = running_out_r;

endmodule

FILE: rtl/encoder_spindle_pid.sv
// Top level of the encoder-fed spindle speed controller.
//
//  channel   dir  payload                                            handshake
//  in_ch     in   encoder_count, setpoint_rpm, start_cmd, stop_cmd  valid/ready
//  out_ch    out  pwm_duty, measured_rpm, running                   valid/ready
//  cfg_*     in   cfg_idx (3b), cfg_data (32b)                      cfg_we only
//
// A tick is made of the input transfer, eight sequencer steps, and the
// commit that loads the result register; the next input transfer can follow
// in the cycle after the commit. The sequence is
// bound by one shared 33x33 signed multiplier used five times per tick
// (speed, divide by ten, I, P and D terms), each product registered.
// Synchronous active-low reset puts config and loop state at their defaults
// and the spindle off. A new tick is taken as soon as the sequencer is idle,
// even while the previous result waits in the output register; a stalled
// output holds the sequencer at commit until the result is taken.
module encoder_spindle_pid (
  input  logic              clk,
  input  logic              rst_n,
  esp_in_if.sink            in_ch,
  esp_out_if.source         out_ch,
  input  logic              cfg_we,
  input  esp_pkg::cfg_idx_t cfg_idx,
  input  logic       [31:0] cfg_data
);

  esp_pkg::cmd_t cmd;

  // handshakes and step sequencing
  esp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // arithmetic, loop state and result register
  esp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_count  (in_ch.encoder_count),
    .in_target (in_ch.setpoint_rpm),
    .in_start  (in_ch.start_cmd),
    .in_stop   (in_ch.stop_cmd),
    .duty_o    (out_ch.pwm_duty),
    .rpm_o     (out_ch.measured_rpm),
    .running_o (out_ch.running)
  );

endmodule

FILE: test/esp_tick_checker.sv
// Scoreboard for the spindle controller: predicts each tick's result and checks the output.
module esp_tick_checker (
  input  logic              clk,
  input  logic              rst_n,
  esp_in_if                 in_ch,
  esp_out_if                out_ch,
  input  logic              cfg_we,
  input  esp_pkg::cfg_idx_t cfg_idx,
  input  logic       [31:0] cfg_data,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [16:0] duty;
    logic [23:0] rpm;
    logic        running;
  } drive_t;

  drive_t drives_due[$];
  drive_t want, got;
  int     shown;

  // register shadow
  logic [31:0] rpm_scale, kp_gain, ki_gain, kd_gain;
  logic [9:0]  tick_rate;
  logic [16:0] base_duty, max_duty;
  logic [23:0] err_limit;

  // controller state
  logic [31:0] last_mag;
  longint      integ, prev_err;
  logic [15:0] stall_cnt, dead_cnt;
  logic        spin_on;

  function automatic drive_t drive_for_tick(logic [31:0] raw, logic [15:0] tgt,
                                            logic start, logic stop);
    logic [31:0] mag, change;
    logic [63:0] rpm;
    longint      base, duty, err, acc;
    drive_t      r;
    if (start) spin_on = 1'b1;
    if (stop) spin_on = 1'b0;  // stop wins
    mag = raw[31] ? (~raw + 32'd1) : raw;
    change = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
    rpm = (64'(change) * 64'(rpm_scale)) >> 8;
    if (rpm > 64'(esp_pkg::RPM_SAT)) rpm = 64'(esp_pkg::RPM_SAT);
    last_mag = mag;
    base = (base_duty > esp_pkg::DUTY_FULL) ? longint'(esp_pkg::DUTY_FULL)
                                            : longint'(base_duty);
    duty = 0;
    if (spin_on) begin
      if (change == 32'd0) begin
        if (dead_cnt != esp_pkg::TICKS_SAT) dead_cnt++;
        if (dead_cnt > tick_rate) spin_on = 1'b0;  // duty still computed below
      end
      err = (longint'(tgt) * 256 - longint'(rpm)) / 10;
      if (err > longint'(err_limit)) err = longint'(err_limit);
      acc = integ + ((longint'(ki_gain) * err) >>> 16);
      if (acc < -65536) acc = -65536;
      else if (acc > 65536) acc = 65536;
      integ = acc;
      duty = base + ((longint'(kp_gain) * err) >>> 16) + integ
           + ((longint'(kd_gain) * (err - prev_err)) >>> 16);
      if (duty < 0) duty = 0;
      else if (duty > 65536) duty = 65536;
      prev_err = err;
      if (duty > longint'(max_duty)) duty = longint'(max_duty);
      // start-up / stall hold, ignores max_duty
      if (rpm < 64'(esp_pkg::HOLD_RPM) || int'(stall_cnt) * 4 < int'(tick_rate) * 3) begin
        duty = base;
        integ = 0;
        prev_err = 0;
        if (stall_cnt != esp_pkg::TICKS_SAT) stall_cnt++;
      end
    end else begin
      integ = 0;
      stall_cnt = '0;
      dead_cnt = '0;
    end
    r.duty = duty[16:0];
    r.rpm = rpm[23:0];
    r.running = spin_on;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rpm_scale  = esp_pkg::RST_RPM_SCALE;
      tick_rate  = esp_pkg::RST_TICK_RATE;
      base_duty  = esp_pkg::RST_BASE_DUTY;
      kp_gain    = esp_pkg::RST_KP;
      ki_gain    = esp_pkg::RST_KI_PER_TICK;
      kd_gain    = esp_pkg::RST_KD_TIMES_RATE;
      err_limit  = esp_pkg::RST_ERROR_LIMIT;
      max_duty   = esp_pkg::RST_MAX_DUTY;
      last_mag   = '0;
      integ      = 0;
      prev_err   = 0;
      stall_cnt  = '0;
      dead_cnt   = '0;
      spin_on    = 1'b0;
      drives_due.delete();
      fail_count = 0;
      shown      = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          esp_pkg::REG_RPM_SCALE:     rpm_scale = cfg_data;
          esp_pkg::REG_TICK_RATE:     tick_rate = cfg_data[9:0];
          esp_pkg::REG_BASE_DUTY:     base_duty = cfg_data[16:0];
          esp_pkg::REG_KP:            kp_gain   = cfg_data;
          esp_pkg::REG_KI_PER_TICK:   ki_gain   = cfg_data;
          esp_pkg::REG_KD_TIMES_RATE: kd_gain   = cfg_data;
          esp_pkg::REG_ERROR_LIMIT:   err_limit = cfg_data[23:0];
          esp_pkg::REG_MAX_DUTY:      max_duty  = cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.duty = out_ch.pwm_duty;
        got.rpm = out_ch.measured_rpm;
        got.running = out_ch.running;
        if (drives_due.size() == 0) begin
          if (shown < 10) begin
            $display("unexpected result: duty %0d rpm %0d running %0d",
                     got.duty, got.rpm, got.running);
            shown++;
          end
          fail_count++;
        end else begin
          want = drives_due.pop_front();
          if (want != got) begin
            if (shown < 10) begin
              $display("mismatch (exp/act): duty %0d/%0d rpm %0d/%0d running %0d/%0d",
                       want.duty, got.duty, want.rpm, got.rpm, want.running, got.running);
              shown++;
            end
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        drives_due.push_back(drive_for_tick(in_ch.encoder_count, in_ch.setpoint_rpm,
                                            in_ch.start_cmd, in_ch.stop_cmd));
    end
    pending = drives_due.size();
  end

endmodule

FILE: test/tb_encoder_spindle_pid.sv
// Testbench top for the spindle controller: stimulus, flow control and the verdict.
module tb_encoder_spindle_pid ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 300;
  localparam int RAND_PHASES     = 6;
  localparam int DRAIN_CYCLES    = 16;   // margin after the last result before the register writes
  localparam int WATCHDOG_LIMIT  = 4000; // covers the long hold-off plus drains
  localparam int SQUEEZE_CYCLES  = 400;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  esp_pkg::cfg_idx_t cfg_idx;
  logic [31:0]       cfg_data;
  int                fail_count;
  int                open_ticks;
  int                idle_cycles;
  int                squeeze_asks;

  // register values to load at the next idle point, indexed by register
  logic [31:0] reg_plan [8];

  // encoder trajectory for the well-formed random ticks
  logic [31:0] enc_pos;
  int          enc_step;
  logic [15:0] tgt_set;
  int          quiet_left;
  int          burst_left;

  esp_in_if  in_ch();
  esp_out_if out_ch();

  encoder_spindle_pid dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  esp_tick_checker tick_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (open_ticks)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One tick offered at a falling edge, held until the transfer.
  // Returns at the next falling edge with valid still high, so a following
  // tick never sees valid dropped and raised in the same step.
  task automatic send_tick(logic [31:0] cnt, logic [15:0] tgt, logic st, logic sp);
    in_ch.valid = 1'b1;
    in_ch.encoder_count = cnt;
    in_ch.setpoint_rpm = tgt;
    in_ch.start_cmd = st;
    in_ch.stop_cmd = sp;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drain: stop offering, wait for every expected result, then let the
  // sequencer finish before anything touches the registers.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (open_ticks != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // All eight registers in index order, one write per cycle.
  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we = 1'b1;
      cfg_idx = esp_pkg::cfg_idx_t'(i);
      cfg_data = reg_plan[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic plan_defaults();
    reg_plan[esp_pkg::REG_RPM_SCALE]     = esp_pkg::RST_RPM_SCALE;
    reg_plan[esp_pkg::REG_TICK_RATE]     = 32'(esp_pkg::RST_TICK_RATE);
    reg_plan[esp_pkg::REG_BASE_DUTY]     = 32'(esp_pkg::RST_BASE_DUTY);
    reg_plan[esp_pkg::REG_KP]            = esp_pkg::RST_KP;
    reg_plan[esp_pkg::REG_KI_PER_TICK]   = esp_pkg::RST_KI_PER_TICK;
    reg_plan[esp_pkg::REG_KD_TIMES_RATE] = esp_pkg::RST_KD_TIMES_RATE;
    reg_plan[esp_pkg::REG_ERROR_LIMIT]   = 32'(esp_pkg::RST_ERROR_LIMIT);
    reg_plan[esp_pkg::REG_MAX_DUTY]      = 32'(esp_pkg::RST_MAX_DUTY);
  endtask

  // Receiver: switches between always-ready, coin-flip and sparse patterns,
  // and on request from the stimulus holds off for a long stretch so the
  // block fills up and pushes back on its input.
  initial begin
    rx_mode_t mode;
    int mode_left, rx_cycle, hold_left, squeeze_seen;
    out_ch.ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    rx_cycle = 0;
    hold_left = 0;
    squeeze_seen = 0;
    forever begin
      @(negedge clk);
      if (squeeze_asks != squeeze_seen) begin
        squeeze_seen = squeeze_asks;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        rx_cycle++;
        case (mode)
          RX_OPEN:   out_ch.ready = 1'b1;
          RX_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready = (rx_cycle % 4 == 0);
          default:   out_ch.ready = 1'b1;
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    int pick;
    logic [31:0] cnt;
    logic [15:0] tgt;
    logic st, sp;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = esp_pkg::REG_RPM_SCALE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.encoder_count = '0;
    in_ch.setpoint_rpm = '0;
    in_ch.start_cmd = 1'b0;
    in_ch.stop_cmd = 1'b0;
    idle_cycles = 0;
    squeeze_asks = 0;
    enc_pos = '0;
    enc_step = 40;
    tgt_set = 16'd500;
    quiet_left = 0;
    burst_left = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part one: short hold (tick rate 2), base duty above full
    // scale so it is taken as full, and a duty ceiling below full.
    plan_defaults();
    reg_plan[esp_pkg::REG_TICK_RATE] = 32'd2;
    reg_plan[esp_pkg::REG_BASE_DUTY] = 32'd70000;
    reg_plan[esp_pkg::REG_MAX_DUTY]  = 32'd40000;
    write_regs();
    send_tick(32'd0, 16'd0, 1'b0, 1'b0);               // off: zero duty
    send_tick(32'd0, 16'd65535, 1'b1, 1'b1);           // both commands: stop wins
    send_tick(32'd100, 16'd1000, 1'b1, 1'b0);          // start, held at base
    send_tick(32'd200, 16'd1000, 1'b0, 1'b0);          // still in time hold
    send_tick(32'd300, 16'd1000, 1'b0, 1'b0);          // loop closes, ceiling applies
    send_tick(32'd400, 16'd65535, 1'b0, 1'b0);         // error clamped from above
    send_tick(-32'sd500, 16'd65535, 1'b0, 1'b0);       // negative count, magnitude used
    send_tick(32'h8000_0000, 16'd0, 1'b0, 1'b0);       // encoder minimum, speed saturates
    send_tick(32'h7FFF_FFFF, 16'd0, 1'b0, 1'b0);       // one count: below hold speed
    send_tick(32'h7FFF_FFFF, 16'd300, 1'b0, 1'b0);     // dead encoder ticks ...
    send_tick(32'h7FFF_FFFF, 16'd300, 1'b0, 1'b0);
    send_tick(32'h7FFF_FFFF, 16'd300, 1'b0, 1'b0);     // ... past the limit: shut off
    send_tick(32'h7FFF_FFFF, 16'd300, 1'b0, 1'b0);
    send_tick(32'd1000, 16'd0, 1'b1, 1'b0);
    send_tick(32'd1000, 16'd0, 1'b0, 1'b1);

    // Directed part two: zero tick rate, full-scale gains, widest error
    // limit; drives the integral into both clamps.
    settle();
    reg_plan[esp_pkg::REG_RPM_SCALE]     = 32'h0001_0000;
    reg_plan[esp_pkg::REG_TICK_RATE]     = 32'd0;
    reg_plan[esp_pkg::REG_BASE_DUTY]     = 32'd0;
    reg_plan[esp_pkg::REG_KP]            = 32'hFFFF_FFFF;
    reg_plan[esp_pkg::REG_KI_PER_TICK]   = 32'hFFFF_FFFF;
    reg_plan[esp_pkg::REG_KD_TIMES_RATE] = 32'hFFFF_FFFF;
    reg_plan[esp_pkg::REG_ERROR_LIMIT]   = 32'h00FF_FFFF;
    reg_plan[esp_pkg::REG_MAX_DUTY]      = 32'd65536;
    write_regs();
    send_tick(32'd0, 16'd65535, 1'b1, 1'b0);           // no time hold at rate zero
    send_tick(32'd0, 16'd0, 1'b0, 1'b0);               // first dead tick already shuts off
    send_tick(32'd40, 16'd0, 1'b1, 1'b0);              // negative error, integral floor
    send_tick(32'd80, 16'd0, 1'b0, 1'b0);

    // Random part: several register settings, each with its own run of ticks.
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p)
        0: plan_defaults();
        1: begin
          // saturating speed scale, long hold (tick rate 1000), everything else zero
          reg_plan[esp_pkg::REG_RPM_SCALE]     = 32'hFFFF_FFFF;
          reg_plan[esp_pkg::REG_TICK_RATE]     = 32'd1000;
          reg_plan[esp_pkg::REG_BASE_DUTY]     = 32'd0;
          reg_plan[esp_pkg::REG_KP]            = 32'd0;
          reg_plan[esp_pkg::REG_KI_PER_TICK]   = 32'd0;
          reg_plan[esp_pkg::REG_KD_TIMES_RATE] = 32'd0;
          reg_plan[esp_pkg::REG_ERROR_LIMIT]   = 32'd0;
          reg_plan[esp_pkg::REG_MAX_DUTY]      = 32'd0;
        end
        2: begin
          reg_plan[esp_pkg::REG_RPM_SCALE]     = 32'h0004_0000;
          reg_plan[esp_pkg::REG_TICK_RATE]     = 32'd1;
          reg_plan[esp_pkg::REG_BASE_DUTY]     = 32'h1_FFFF;
          reg_plan[esp_pkg::REG_KP]            = 32'hFFFF_FFFF;
          reg_plan[esp_pkg::REG_KI_PER_TICK]   = 32'hFFFF_FFFF;
          reg_plan[esp_pkg::REG_KD_TIMES_RATE] = 32'hFFFF_FFFF;
          reg_plan[esp_pkg::REG_ERROR_LIMIT]   = 32'h00FF_FFFF;
          reg_plan[esp_pkg::REG_MAX_DUTY]      = 32'd65536;
        end
        default: begin
          // gains spread over many magnitudes; tick rate over the whole field
          reg_plan[esp_pkg::REG_RPM_SCALE]     = $urandom_range(32'h2000, 32'h10_0000);
          reg_plan[esp_pkg::REG_TICK_RATE]     = $urandom_range(0, 1023);
          reg_plan[esp_pkg::REG_BASE_DUTY]     = $urandom_range(0, 32'h1_FFFF);
          reg_plan[esp_pkg::REG_KP]            = $urandom >> $urandom_range(4, 31);
          reg_plan[esp_pkg::REG_KI_PER_TICK]   = $urandom >> $urandom_range(4, 31);
          reg_plan[esp_pkg::REG_KD_TIMES_RATE] = $urandom >> $urandom_range(4, 31);
          reg_plan[esp_pkg::REG_ERROR_LIMIT]   =
            $urandom_range(0, 32'hFF_FFFF) >> $urandom_range(0, 12);
          reg_plan[esp_pkg::REG_MAX_DUTY]      = $urandom_range(0, 32'h1_FFFF);
        end
      endcase
      write_regs();
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == 20) squeeze_asks++;  // long receiver hold-off mid-phase
        pick = $urandom_range(0, 99);
        st = 1'b0;
        sp = 1'b0;
        if (pick < 8) begin
          // noise: any value of any field
          cnt = $urandom;
          tgt = 16'($urandom_range(0, 65535));
          st = 1'($urandom_range(0, 1));
          sp = 1'($urandom_range(0, 1));
        end else begin
          // well-formed: a spindle turning at a step rate that drifts, with
          // occasional dead stretches that trip the encoder-loss shutdown
          if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 3))
              0: enc_step = $urandom_range(0, 8);
              1: enc_step = $urandom_range(9, 300);
              2: enc_step = $urandom_range(300, 20000);
              default: enc_step = -int'($urandom_range(1, 500));
            endcase
          end
          if ($urandom_range(0, 29) == 0) begin
            case ($urandom_range(0, 3))
              0: tgt_set = 16'd0;
              1: tgt_set = 16'hFFFF;
              2: tgt_set = 16'($urandom_range(0, 65535));
              default: tgt_set = 16'($urandom_range(0, 3000));
            endcase
          end
          if (quiet_left > 0) quiet_left--;
          else if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(1, 40);
          if (quiet_left == 0) enc_pos = enc_pos + enc_step + $urandom_range(0, 2) - 1;
          if (pick == 8) enc_pos = 32'h8000_0000;
          else if (pick == 9) enc_pos = 32'h7FFF_FFFF;
          cnt = enc_pos;
          tgt = tgt_set;
          st = (n == 0) || ($urandom_range(0, 24) == 0);
          sp = ($urandom_range(0, 59) == 0);
        end
        send_tick(cnt, tgt, st, sp);
        // sender bursts; a quarter of bursts run straight into the next
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
          end
        end
      end
    end

    settle();
    if (fail_count == 0 && open_ticks == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: encoder_spindle_pid.f
rtl/esp_pkg.sv
rtl/esp_in_if.sv
rtl/esp_out_if.sv
rtl/esp_ctrl.sv
rtl/esp_dp.sv
rtl/encoder_spindle_pid.sv
test/esp_tick_checker.sv
test/tb_encoder_spindle_pid.sv
